>>> rtl/core/ust_pkg.sv
// Shared types and constants of the UDP port socket table.
package ust_pkg;

  localparam int Entries = 40;
  localparam int SlotAw = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int SockW = 6;
  localparam int PortW = 16;
  localparam int CtxW = 16;
  localparam logic [PortW-1:0] EphBase = 16'd49152;
  localparam logic [PortW-1:0] EphLast = 16'hFFFF;
  localparam logic [SlotAw-1:0] LastIdx = SlotAw'(Entries - 1);

  typedef enum logic [1:0] {
    OpBind   = 2'd0,
    OpLookup = 2'd1,
    OpQuery  = 2'd2,
    OpClose  = 2'd3
  } ust_op_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StBound = 2'd2,
    StMiss  = 2'd3
  } ust_status_e;

  typedef enum logic [2:0] {
    StateIdle,
    StateScan,
    StateProbe,
    StateCheck,
    StateFin
  } ust_state_e;

  typedef struct packed {
    logic              en;
    logic [SlotAw-1:0] addr;
  } ust_rd_t;

  typedef struct packed {
    logic              en;
    logic              set;
    logic [SlotAw-1:0] addr;
    logic [PortW-1:0]  port;
    logic [CtxW-1:0]   ctx;
  } ust_wr_t;

  typedef struct packed {
    logic             valid;
    logic [PortW-1:0] port;
    logic [CtxW-1:0]  ctx;
  } ust_slot_t;

  typedef struct packed {
    ust_status_e      status;
    logic [SockW-1:0] socket;
    logic [PortW-1:0] port;
    logic [CtxW-1:0]  ctx;
  } ust_res_t;

endpackage

>>> rtl/core/udp_port_socket_table.sv
// Top level of the UDP port socket table with its output register.
//
// The input channel (in_valid_i, in_ready_o) carries one command word: an
// opcode with a port, a socket index and a context tag. The output channel
// (out_valid_o, out_ready_i) returns exactly one result word per command.
// Bind and lookup walk the slots in index order through one port comparator
// fed by the slot memory, one slot per cycle, and stop at the first match or
// after the last slot. Query and close read one slot. The block holds one
// command at a time and raises in_ready_o again once its result has moved
// into the output register. After reset all slots are free and the
// ephemeral counter starts at 49152; the valid flags clear at once, so no
// clearing pass is needed. When the receiver stalls, the result stays in the
// output register unchanged, and a finished command waits until it drains.
module udp_port_socket_table (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [1:0]                opcode_i,
  input  logic [ust_pkg::PortW-1:0] port_i,
  input  logic [ust_pkg::SockW-1:0] socket_i,
  input  logic [ust_pkg::CtxW-1:0]  ctx_tag_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [1:0]                status_o,
  output logic [ust_pkg::SockW-1:0] socket_res_o,
  output logic [ust_pkg::PortW-1:0] bound_port_o,
  output logic [ust_pkg::CtxW-1:0]  ctx_out_o
);
  import ust_pkg::*;

  ust_rd_t   rd;
  ust_wr_t   wr;
  ust_slot_t slot;
  ust_res_t  res;
  logic      res_valid;
  logic      take;
  logic      idle;
  logic      out_valid_q, out_valid_d;
  ust_res_t  out_q;

  assign take       = res_valid && (!out_valid_q || out_ready_i);
  assign in_ready_o = idle;

  ust_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rd),
    .wr_i   (wr),
    .slot_o (slot)
  );

  ust_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_valid_i && in_ready_o),
    .opcode_i    (opcode_i),
    .port_i      (port_i),
    .socket_i    (socket_i),
    .ctx_tag_i   (ctx_tag_i),
    .slot_i      (slot),
    .take_i      (take),
    .idle_o      (idle),
    .rd_o        (rd),
    .wr_o        (wr),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_q.status;
  assign socket_res_o = out_q.socket;
  assign bound_port_o = out_q.port;
  assign ctx_out_o    = out_q.ctx;

endmodule

>>> rtl/core/ust_store.sv
// Slot store: valid flops plus a port and context memory with a registered read.
module ust_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ust_pkg::ust_rd_t   rd_i,
  input  ust_pkg::ust_wr_t   wr_i,
  output ust_pkg::ust_slot_t slot_o
);
  import ust_pkg::*;

  logic [Entries-1:0]     valid_q;
  logic [PortW+CtxW-1:0]  mem [Entries];
  logic [PortW+CtxW-1:0]  rdata_q;
  logic                   rvalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= wr_i.set;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.set) begin
      mem[wr_i.addr] <= {wr_i.port, wr_i.ctx};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q <= 1'b0;
    end else if (rd_i.en) begin
      rvalid_q <= valid_q[rd_i.addr];
    end
  end

  assign slot_o.valid = rvalid_q;
  assign slot_o.port  = rvalid_q ? rdata_q[PortW+CtxW-1:CtxW] : '0;
  assign slot_o.ctx   = rvalid_q ? rdata_q[CtxW-1:0] : '0;

endmodule

>>> rtl/core/ust_ctrl.sv
// Sequencer that scans the slots through one shared port comparator.
module ust_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [1:0]               opcode_i,
  input  logic [ust_pkg::PortW-1:0] port_i,
  input  logic [ust_pkg::SockW-1:0] socket_i,
  input  logic [ust_pkg::CtxW-1:0]  ctx_tag_i,
  input  ust_pkg::ust_slot_t       slot_i,
  input  logic                     take_i,
  output logic                     idle_o,
  output ust_pkg::ust_rd_t         rd_o,
  output ust_pkg::ust_wr_t         wr_o,
  output logic                     res_valid_o,
  output ust_pkg::ust_res_t        res_o
);
  import ust_pkg::*;

  ust_state_e        state_q, state_d;
  ust_op_e           op_q, op_d;
  logic [PortW-1:0]  prt_q, prt_d;
  logic [SockW-1:0]  sock_q, sock_d;
  logic [CtxW-1:0]   ctx_q, ctx_d;
  logic [PortW-1:0]  eph_q, eph_d;
  logic [SlotAw-1:0] idx_q, idx_d;
  logic              issue_q, issue_d;
  logic              chk_vld_q, chk_vld_d;
  logic [SlotAw-1:0] chk_idx_q, chk_idx_d;
  logic [SlotAw-1:0] free_q, free_d;
  logic              free_found_q, free_found_d;
  ust_res_t          res_q, res_d;

  logic              hit;
  logic              chk_last;
  logic              in_range;
  ust_op_e           op_in;

  assign op_in    = ust_op_e'(opcode_i);
  assign hit      = chk_vld_q && slot_i.valid && (slot_i.port == prt_q);
  assign chk_last = (chk_idx_q == LastIdx);
  assign in_range = ({1'b0, sock_q} < (SockW + 1)'(Entries));

  always_comb begin
    state_d = state_q;
    case (state_q)
      StateIdle: begin
        if (start_i) begin
          state_d = (op_in == OpBind || op_in == OpLookup) ? StateScan : StateProbe;
        end
      end
      StateScan: begin
        if (chk_vld_q && (hit || chk_last)) begin
          state_d = StateFin;
        end
      end
      StateProbe: state_d = StateCheck;
      StateCheck: state_d = StateFin;
      StateFin: begin
        if (take_i) begin
          state_d = StateIdle;
        end
      end
      default: state_d = StateIdle;
    endcase
  end

  always_comb begin
    op_d         = op_q;
    prt_d        = prt_q;
    sock_d       = sock_q;
    ctx_d        = ctx_q;
    eph_d        = eph_q;
    idx_d        = idx_q;
    issue_d      = issue_q;
    chk_vld_d    = 1'b0;
    chk_idx_d    = chk_idx_q;
    free_d       = free_q;
    free_found_d = free_found_q;
    res_d        = res_q;
    rd_o         = '0;
    wr_o         = '0;
    case (state_q)
      StateIdle: begin
        if (start_i) begin
          op_d         = op_in;
          sock_d       = socket_i;
          ctx_d        = ctx_tag_i;
          prt_d        = port_i;
          idx_d        = '0;
          issue_d      = 1'b1;
          free_found_d = 1'b0;
          if (op_in == OpBind && port_i == '0) begin
            prt_d = eph_q;
            eph_d = (eph_q == EphLast) ? EphBase : eph_q + 16'd1;
          end
        end
      end
      StateScan: begin
        rd_o.en   = issue_q;
        rd_o.addr = idx_q;
        chk_vld_d = issue_q;
        chk_idx_d = idx_q;
        if (issue_q) begin
          if (idx_q == LastIdx) begin
            issue_d = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
        if (chk_vld_q && !slot_i.valid) begin
          free_d       = chk_idx_q;
          free_found_d = 1'b1;
        end
        if (hit) begin
          res_d.socket = SockW'(chk_idx_q);
          res_d.ctx    = slot_i.ctx;
          if (op_q == OpBind) begin
            res_d.status = StBound;
            res_d.port   = prt_q;
          end else begin
            res_d.status = StOk;
            res_d.port   = slot_i.port;
          end
        end else if (chk_vld_q && chk_last) begin
          if (op_q == OpBind) begin
            if (free_found_q || !slot_i.valid) begin
              wr_o.en      = 1'b1;
              wr_o.set     = 1'b1;
              wr_o.addr    = slot_i.valid ? free_q : chk_idx_q;
              wr_o.port    = prt_q;
              wr_o.ctx     = ctx_q;
              res_d.status = StOk;
              res_d.socket = SockW'(wr_o.addr);
              res_d.port   = prt_q;
              res_d.ctx    = ctx_q;
            end else begin
              res_d.status = StFull;
              res_d.socket = '0;
              res_d.port   = prt_q;
              res_d.ctx    = '0;
            end
          end else begin
            res_d = '{status: StMiss, socket: '0, port: '0, ctx: '0};
          end
        end
      end
      StateProbe: begin
        rd_o.en   = 1'b1;
        rd_o.addr = sock_q[SlotAw-1:0];
      end
      StateCheck: begin
        res_d.socket = sock_q;
        res_d.port   = '0;
        res_d.ctx    = '0;
        res_d.status = (in_range && slot_i.valid) ? StOk : StMiss;
        if (op_q == OpQuery) begin
          if (in_range && slot_i.valid) begin
            res_d.port = slot_i.port;
            res_d.ctx  = slot_i.ctx;
          end
        end else if (in_range) begin
          wr_o.en   = 1'b1;
          wr_o.set  = 1'b0;
          wr_o.addr = sock_q[SlotAw-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StateIdle;
      eph_q        <= EphBase;
      issue_q      <= 1'b0;
      chk_vld_q    <= 1'b0;
      free_found_q <= 1'b0;
      idx_q        <= '0;
    end else begin
      state_q      <= state_d;
      eph_q        <= eph_d;
      issue_q      <= issue_d;
      chk_vld_q    <= chk_vld_d;
      free_found_q <= free_found_d;
      idx_q        <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    prt_q     <= prt_d;
    sock_q    <= sock_d;
    ctx_q     <= ctx_d;
    chk_idx_q <= chk_idx_d;
    free_q    <= free_d;
    res_q     <= res_d;
  end

  assign idle_o      = (state_q == StateIdle);
  assign res_valid_o = (state_q == StateFin);
  assign res_o       = res_q;

endmodule

>>> rtl/core/ust_checker.sv
// Port-level checker for the UDP port socket table and its bind statement.
module ust_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_o,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [1:0]                status_o,
  input logic [ust_pkg::SockW-1:0] socket_res_o,
  input logic [ust_pkg::PortW-1:0] bound_port_o,
  input logic [ust_pkg::CtxW-1:0]  ctx_out_o
);
  import ust_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(socket_res_o) && $stable(bound_port_o) && $stable(ctx_out_o))
    else $error("Stalled result word changed.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input accepted again while a command is in progress.");

  a_full_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StFull |-> socket_res_o == '0 && ctx_out_o == '0)
    else $error("Full result carries a slot or a context.");

  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StMiss |-> bound_port_o == '0 && ctx_out_o == '0)
    else $error("Miss result carries a port or a context.");

endmodule

bind udp_port_socket_table ust_checker u_ust_checker (.*);
